// ----- sv/matrix_multiply_transpose_assert.svh -----
// Assertion macros shared by the matrix multiply checker.
// Depends on a clk and an active-low rst_n in the scope of use.
`ifndef MATRIX_MULTIPLY_TRANSPOSE_ASSERT_SVH
`define MATRIX_MULTIPLY_TRANSPOSE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MMT_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MMT_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mmt_pkg.sv -----
// Shared types, constants and helpers for the matrix multiply block.
// No dependencies.
package mmt_pkg;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int ADDR_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + $clog2(MAX_DIM) + 1;

  localparam logic [1:0] REQ_WR_A  = 2'd0;
  localparam logic [1:0] REQ_WR_B  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TR_A   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TR_B   = 3'd5;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(MAX_DIM);

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_ERR
  } mmt_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] a_rows;
    logic [CFG_W-1:0] a_cols;
    logic [CFG_W-1:0] b_rows;
    logic [CFG_W-1:0] b_cols;
    logic             tr_a;
    logic             tr_b;
  } cfg_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] value;
    logic              sat;
  } mac_res_t;

  // Size register to dimension minus one: zero acts as one, large clamps.
  function automatic logic [IDX_W-1:0] dim_m1(input logic [CFG_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v == '0) r = '0;
    else if (int'(v) > MAX_DIM) r = IDX_W'(MAX_DIM - 1);
    else r = IDX_W'(v - CFG_W'(1));
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

endpackage

// ----- sv/mmt_store.sv -----
// One matrix store: single write port, registered read port.
// Depends on mmt_pkg.
module mmt_store
  import mmt_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [MAX_DIM*MAX_DIM];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/mmt_mac.sv -----
// Shared multiply-accumulate unit with shift-back and saturation.
// Depends on mmt_pkg.
module mmt_mac
  import mmt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mac_ctl_t          ctl,
  input  logic [DATA_W-1:0] a_data,
  input  logic [DATA_W-1:0] b_data,
  output mac_res_t          res
);

  mac_ctl_t                  s1_r, s2_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      res_vld_r, res_vld_nxt;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   shifted;
  logic                      in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r      <= '0;
      s2_r      <= '0;
      res_vld_r <= 1'b0;
    end else begin
      s1_r      <= ctl;
      s2_r      <= s1_r;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(a_data) * $signed(b_data);
    acc_r  <= acc_nxt;
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    acc_nxt     = acc_r;
    res_vld_nxt = res_vld_r;
    if (ctl.vld) res_vld_nxt = 1'b0;
    if (s2_r.vld) begin
      acc_nxt = s2_r.first ? prod_ext : acc_r + prod_ext;
      if (s2_r.last) res_vld_nxt = 1'b1;
    end
  end

  // Arithmetic shift floors; the result fits when all upper bits match the sign.
  assign shifted  = acc_r >>> FRAC_BITS;
  assign in_range = (&shifted[ACC_W-1:DATA_W-1]) | ~(|shifted[ACC_W-1:DATA_W-1]);

  always_comb begin
    res.vld   = res_vld_r;
    res.sat   = ~in_range;
    res.value = in_range ? shifted[DATA_W-1:0] : (acc_r[ACC_W-1] ? SAT_MIN : SAT_MAX);
  end

endmodule

// ----- sv/mmt_ctrl.sv -----
// Sequencer: walks result elements and the inner index, owns the output register.
// Depends on mmt_pkg.
module mmt_ctrl
  import mmt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  logic [1:0]        in_req_type,
  output logic              in_stall,
  output mac_ctl_t          mac_ctl,
  output logic [ADDR_W-1:0] a_addr,
  output logic [ADDR_W-1:0] b_addr,
  input  mac_res_t          mac_res,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_product_value,
  output logic [IDX_W-1:0]  out_result_row,
  output logic [IDX_W-1:0]  out_result_col,
  output logic              out_last_result,
  output logic              out_dim_error,
  output logic              out_saturated
);

  mmt_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IDX_W-1:0] m_m1_r, n_m1_r, k_m1_r;
  logic             ta_r, tb_r;
  logic [IDX_W-1:0] ar_m1, ac_m1, br_m1, bc_m1, ka_m1, kb_m1;
  logic             start, mismatch, out_free, last_elem, k_last;
  logic             load_res, load_err;
  logic             out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] value_r;
  logic [IDX_W-1:0] row_r, col_r;
  logic             last_r, err_r, sat_r;

  assign ar_m1    = dim_m1(cfg.a_rows);
  assign ac_m1    = dim_m1(cfg.a_cols);
  assign br_m1    = dim_m1(cfg.b_rows);
  assign bc_m1    = dim_m1(cfg.b_cols);
  assign ka_m1    = cfg.tr_a ? ar_m1 : ac_m1;
  assign kb_m1    = cfg.tr_b ? bc_m1 : br_m1;
  assign mismatch = ka_m1 != kb_m1;

  assign start     = in_valid && !in_stall && in_req_type == REQ_START;
  assign out_free  = !out_valid_r || !out_stall;
  assign k_last    = k_r == k_m1_r;
  assign last_elem = i_r == m_m1_r && j_r == n_m1_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = mismatch ? ST_ERR : ST_ISSUE;
      ST_ISSUE: if (k_last) state_nxt = ST_WAIT;
      ST_WAIT:  if (mac_res.vld && out_free) state_nxt = last_elem ? ST_IDLE : ST_ISSUE;
      ST_ERR:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = state_r != ST_IDLE;
    mac_ctl.vld   = state_r == ST_ISSUE;
    mac_ctl.first = k_r == '0;
    mac_ctl.last  = k_last;
    load_res      = state_r == ST_WAIT && mac_res.vld && out_free;
    load_err      = state_r == ST_ERR && out_free;
  end

  assign a_addr = ta_r ? elem_addr(k_r, i_r) : elem_addr(i_r, k_r);
  assign b_addr = tb_r ? elem_addr(j_r, k_r) : elem_addr(k_r, j_r);

  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    if (start) begin
      i_nxt = '0;
      j_nxt = '0;
      k_nxt = '0;
    end
    if (mac_ctl.vld) k_nxt = k_last ? '0 : k_r + IDX_W'(1);
    if (load_res) begin
      if (j_r == n_m1_r) begin
        j_nxt = '0;
        i_nxt = i_r + IDX_W'(1);
      end else begin
        j_nxt = j_r + IDX_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (load_res || load_err) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    if (start) begin
      m_m1_r <= cfg.tr_a ? ac_m1 : ar_m1;
      n_m1_r <= cfg.tr_b ? br_m1 : bc_m1;
      k_m1_r <= ka_m1;
      ta_r   <= cfg.tr_a;
      tb_r   <= cfg.tr_b;
    end
    if (load_res) begin
      value_r <= mac_res.value;
      row_r   <= i_r;
      col_r   <= j_r;
      last_r  <= last_elem;
      err_r   <= 1'b0;
      sat_r   <= mac_res.sat;
    end else if (load_err) begin
      value_r <= '0;
      row_r   <= '0;
      col_r   <= '0;
      last_r  <= 1'b1;
      err_r   <= 1'b1;
      sat_r   <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product_value = value_r;
  assign out_result_row    = row_r;
  assign out_result_col    = col_r;
  assign out_last_result   = last_r;
  assign out_dim_error     = err_r;
  assign out_saturated     = sat_r;

endmodule

// ----- sv/matrix_multiply_transpose.sv -----
// Top level of the fixed-point matrix multiply with optional transposes.
// Depends on mmt_pkg, mmt_store, mmt_mac and mmt_ctrl.
//
// Load A and B one element per transaction (req_type 0 or 1, by row and
// column), then send a start transaction to get C = op(A) x op(B), where op
// transposes a matrix when its transpose register is set. Results leave in
// row-then-column order with last_result on the final one; if the inner
// dimensions disagree a single transaction with dim_error and last_result set
// comes out instead. Values are signed Q16.16; each result sums its products
// exactly, shifts right by the fraction bits (toward minus infinity) and
// saturates to 32 bits, flagging saturated when clipped. All products share
// one multiplier-accumulator: for each result element the k inner products
// are issued one per cycle through the store read, multiply and accumulate
// stages, then the result is loaded into the output register before the next
// element is issued; a stalled output holds the run until the result is taken.
// The input is stalled for the whole run. Store entries are never cleared:
// read only what was written. Change configuration only while idle.
module matrix_multiply_transpose
  import mmt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_req_type,
  input  logic [IDX_W-1:0]         in_row_index,
  input  logic [IDX_W-1:0]         in_col_index,
  input  logic signed [DATA_W-1:0] in_element_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_product_value,
  output logic [IDX_W-1:0]         out_result_row,
  output logic [IDX_W-1:0]         out_result_col,
  output logic                     out_last_result,
  output logic                     out_dim_error,
  output logic                     out_saturated,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  cfg_t              cfg_r, cfg_nxt;
  logic              in_fire, in_bounds, a_we, b_we;
  logic [ADDR_W-1:0] wr_addr, a_rd_addr, b_rd_addr;
  logic [DATA_W-1:0] a_rd_data, b_rd_data;
  logic [DATA_W-1:0] value_q;
  mac_ctl_t          mac_ctl;
  mac_res_t          mac_res;

  // Decode configuration writes; unknown indexes drop.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_A_ROWS: cfg_nxt.a_rows = cfg_data;
        CFG_A_COLS: cfg_nxt.a_cols = cfg_data;
        CFG_B_ROWS: cfg_nxt.b_rows = cfg_data;
        CFG_B_COLS: cfg_nxt.b_cols = cfg_data;
        CFG_TR_A:   cfg_nxt.tr_a   = cfg_data[0];
        CFG_TR_B:   cfg_nxt.tr_b   = cfg_data[0];
        default:    cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.a_rows <= DIM_RESET;
      cfg_r.a_cols <= DIM_RESET;
      cfg_r.b_rows <= DIM_RESET;
      cfg_r.b_cols <= DIM_RESET;
      cfg_r.tr_a   <= 1'b0;
      cfg_r.tr_b   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Element writes go straight into the addressed store; drop any outside the store.
  assign in_fire   = in_valid && !in_stall;
  assign in_bounds = int'(in_row_index) < MAX_DIM && int'(in_col_index) < MAX_DIM;
  assign a_we      = in_fire && in_bounds && in_req_type == REQ_WR_A;
  assign b_we      = in_fire && in_bounds && in_req_type == REQ_WR_B;
  assign wr_addr   = elem_addr(in_row_index, in_col_index);

  mmt_store u_a_store (
    .clk     (clk),
    .wr_en   (a_we),
    .wr_addr (wr_addr),
    .wr_data (in_element_value),
    .rd_en   (mac_ctl.vld),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data)
  );

  mmt_store u_b_store (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (wr_addr),
    .wr_data (in_element_value),
    .rd_en   (mac_ctl.vld),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  mmt_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .a_data (a_rd_data),
    .b_data (b_rd_data),
    .res    (mac_res)
  );

  mmt_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_req_type       (in_req_type),
    .in_stall          (in_stall),
    .mac_ctl           (mac_ctl),
    .a_addr            (a_rd_addr),
    .b_addr            (b_rd_addr),
    .mac_res           (mac_res),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_product_value (value_q),
    .out_result_row    (out_result_row),
    .out_result_col    (out_result_col),
    .out_last_result   (out_last_result),
    .out_dim_error     (out_dim_error),
    .out_saturated     (out_saturated)
  );

  assign out_product_value = $signed(value_q);

endmodule

// ----- sv/mmt_checker.sv -----
// Port-level checks for the matrix multiply block, bound to the top level.
// Depends on mmt_pkg and matrix_multiply_transpose_assert.svh.
`include "matrix_multiply_transpose_assert.svh"

module mmt_checker
  import mmt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] out_product_value,
  input logic              out_last_result,
  input logic              out_dim_error,
  input logic              out_saturated
);

  `MMT_ASSERT_NOW(a_err_is_last, out_valid && out_dim_error, out_last_result, "dim error not last")

  `MMT_ASSERT_NOW(a_err_is_empty, out_valid && out_dim_error, out_product_value == '0 && !out_saturated, "dim error carries data")

  `MMT_ASSERT_NOW(a_sat_extreme, out_valid && out_saturated, out_product_value == SAT_MAX || out_product_value == SAT_MIN, "saturated value not at a rail")

  `MMT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_product_value), "stalled result changed")

endmodule

bind matrix_multiply_transpose mmt_checker u_mmt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_product_value (out_product_value),
  .out_last_result   (out_last_result),
  .out_dim_error     (out_dim_error),
  .out_saturated     (out_saturated)
);

// ----- tb/matrix_multiply_transpose_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for matrix_multiply_transpose: loads A and B, runs
// products under many size and transpose settings and checks each C element.
// Depends on mmt_pkg and the matrix_multiply_transpose RTL.
module matrix_multiply_transpose_test;
  import mmt_pkg::*;

  // Request code the block must ignore.
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam int MAX_GAP         = 15;
  localparam int SETTLE_CYCLES   = 24;    // write items finish well within this
  localparam int HOLD_OFF_CYCLES = 400;   // long output stall for back-pressure
  localparam int RANDOM_ITEMS    = 280;
  localparam int TIMEOUT_NS      = 2_000_000;

  localparam logic signed [71:0] Q_MAX = 72'sd2147483647;
  localparam logic signed [71:0] Q_MIN = -72'sd2147483648;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
    logic              dim_err;
    logic              sat;
  } product_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               in_req_type;
  logic [IDX_W-1:0]         in_row_index;
  logic [IDX_W-1:0]         in_col_index;
  logic signed [DATA_W-1:0] in_element_value;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_product_value;
  logic [IDX_W-1:0]         out_result_row;
  logic [IDX_W-1:0]         out_result_col;
  logic                     out_last_result;
  logic                     out_dim_error;
  logic                     out_saturated;
  logic                     cfg_wr_en;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  // Shadow copy of the block: element stores, which entries hold data,
  // and the size / transpose registers.
  logic [DATA_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic [DATA_W-1:0] b_mem [MAX_DIM*MAX_DIM];
  bit                a_written [MAX_DIM*MAX_DIM];
  bit                b_written [MAX_DIM*MAX_DIM];
  logic [CFG_W-1:0]  size_a_rows = DIM_RESET;
  logic [CFG_W-1:0]  size_a_cols = DIM_RESET;
  logic [CFG_W-1:0]  size_b_rows = DIM_RESET;
  logic [CFG_W-1:0]  size_b_cols = DIM_RESET;
  bit                use_a_t = 1'b0;
  bit                use_b_t = 1'b0;

  product_t expected_products[$];

  int errors             = 0;
  int items_sent         = 0;
  int random_items_start = 0;
  int stall_left         = 0;
  int hold_off_left      = 0;
  bit gaps_on            = 1'b1;

  matrix_multiply_transpose dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_product_value(out_product_value),
    .out_result_row   (out_result_row),
    .out_result_col   (out_result_col),
    .out_last_result  (out_last_result),
    .out_dim_error    (out_dim_error),
    .out_saturated    (out_saturated),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Zero acts as one, anything above the store size clamps to it.
  function automatic int effective_size(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Form C = op(A) x op(B) from the shadow stores and queue every element,
  // or a single error transaction when the inner dimensions disagree.
  function automatic void multiply_stored_matrices();
    int m, n, ka, kb, ia, ib, i, j, k;
    logic signed [71:0] acc, a_w, b_w, scaled;
    product_t p;
    m  = use_a_t ? effective_size(size_a_cols) : effective_size(size_a_rows);
    ka = use_a_t ? effective_size(size_a_rows) : effective_size(size_a_cols);
    kb = use_b_t ? effective_size(size_b_cols) : effective_size(size_b_rows);
    n  = use_b_t ? effective_size(size_b_rows) : effective_size(size_b_cols);
    if (ka != kb) begin
      p = '0;
      p.last    = 1'b1;
      p.dim_err = 1'b1;
      expected_products.push_back(p);
      return;
    end
    for (i = 0; i < m; i++) begin
      for (j = 0; j < n; j++) begin
        acc = '0;
        for (k = 0; k < ka; k++) begin
          ia  = use_a_t ? k * MAX_DIM + i : i * MAX_DIM + k;
          ib  = use_b_t ? j * MAX_DIM + k : k * MAX_DIM + j;
          a_w = $signed(a_mem[ia]);
          b_w = $signed(b_mem[ib]);
          acc = acc + a_w * b_w;
        end
        // Arithmetic shift rounds toward minus infinity, then clip.
        scaled = acc >>> FRAC_BITS;
        p = '0;
        p.row  = IDX_W'(i);
        p.col  = IDX_W'(j);
        p.last = (i == m - 1) && (j == n - 1);
        if (scaled > Q_MAX) begin
          p.value = SAT_MAX;
          p.sat   = 1'b1;
        end else if (scaled < Q_MIN) begin
          p.value = SAT_MIN;
          p.sat   = 1'b1;
        end else begin
          p.value = scaled[DATA_W-1:0];
        end
        expected_products.push_back(p);
      end
    end
  endfunction

  // Apply one accepted transaction to the shadow state.
  function automatic void record_request(input logic [1:0] req,
                                         input logic [IDX_W-1:0] row,
                                         input logic [IDX_W-1:0] col,
                                         input logic [DATA_W-1:0] value);
    int idx;
    idx = int'(row) * MAX_DIM + int'(col);
    case (req)
      REQ_WR_A: begin
        a_mem[idx]     = value;
        a_written[idx] = 1'b1;
      end
      REQ_WR_B: begin
        b_mem[idx]     = value;
        b_written[idx] = 1'b1;
      end
      REQ_START: multiply_stored_matrices();
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result side: stall pattern and checking
  // ---------------------------------------------------------------------

  // Hold the output for the long back-pressure stretch first, then for the
  // per-transaction stall drawn when the previous result left.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    product_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_products.size() == 0) begin
        $error("unexpected result: row %0d col %0d value %h",
               out_result_row, out_result_col, out_product_value);
        errors++;
      end else begin
        want = expected_products.pop_front();
        if (out_product_value !== want.value) begin
          $error("product_value: expected %h, actual %h", want.value, out_product_value);
          errors++;
        end
        if (out_result_row !== want.row) begin
          $error("result_row: expected %0d, actual %0d", want.row, out_result_row);
          errors++;
        end
        if (out_result_col !== want.col) begin
          $error("result_col: expected %0d, actual %0d", want.col, out_result_col);
          errors++;
        end
        if (out_last_result !== want.last) begin
          $error("last_result: expected %b, actual %b", want.last, out_last_result);
          errors++;
        end
        if (out_dim_error !== want.dim_err) begin
          $error("dim_error: expected %b, actual %b", want.dim_err, out_dim_error);
          errors++;
        end
        if (out_saturated !== want.sat) begin
          $error("saturated: expected %b, actual %b", want.sat, out_saturated);
          errors++;
        end
      end
      stall_left = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    end
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Offer one transaction after a random gap and hold it until accepted.
  // With no gap valid stays high straight into the next transaction.
  task automatic send_request(input logic [1:0] req,
                              input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col,
                              input logic [DATA_W-1:0] value);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_row_index     <= row;
    in_col_index     <= col;
    in_element_value <= value;
    do @(posedge clk); while (in_stall);
    record_request(req, row, col, value);
    if (req != REQ_NONE) items_sent++;
  endtask

  task automatic send_start();
    send_request(REQ_START, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                 $urandom());
  endtask

  // Drop valid, drain every expected result, then give trailing writes time.
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all six registers back to back once the block is idle.
  task automatic program_config(input logic [CFG_W-1:0] ar, input logic [CFG_W-1:0] ac,
                                input logic [CFG_W-1:0] br, input logic [CFG_W-1:0] bc,
                                input bit ta, input bit tb);
    logic [CFG_IDX_W-1:0] regs [6];
    logic [CFG_W-1:0]     vals [6];
    regs = '{CFG_A_ROWS, CFG_A_COLS, CFG_B_ROWS, CFG_B_COLS, CFG_TR_A, CFG_TR_B};
    // Transpose registers take bit 0 only; fill the rest with noise.
    vals = '{ar, ac, br, bc, {(CFG_W-1)'($urandom()), ta}, {(CFG_W-1)'($urandom()), tb}};
    settle_idle();
    foreach (regs[i]) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    size_a_rows = ar;
    size_a_cols = ac;
    size_b_rows = br;
    size_b_cols = bc;
    use_a_t     = ta;
    use_b_t     = tb;
  endtask

  // Mix of small Q16.16 values, full-range words and corner values.
  function automatic logic [DATA_W-1:0] random_element();
    case ($urandom_range(0, 4))
      0, 1: return DATA_W'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
      2, 3: return $urandom();
      default: begin
        case ($urandom_range(0, 5))
          0:       return SAT_MAX;
          1:       return SAT_MIN;
          2:       return 32'hFFFF_FFFF;
          3:       return '0;
          4:       return 32'h0001_0000;
          default: return 32'h0000_0001;
        endcase
      end
    endcase
  endfunction

  // Register value for a dimension, sometimes through the zero or
  // above-range aliases.
  function automatic logic [CFG_W-1:0] encode_dim(input int d);
    if (d == 1 && $urandom_range(0, 3) == 0) return '0;
    if (d == MAX_DIM && $urandom_range(0, 1) == 1)
      return CFG_W'($urandom_range(MAX_DIM + 1, 15));
    return CFG_W'(d);
  endfunction

  // Fill one stored matrix region: every entry not yet written, plus random
  // rewrites, with ignored requests and stray writes mixed in.
  task automatic load_region(input bit is_b, input int rows, input int cols);
    int r, c;
    bit have;
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < cols; c++) begin
        if ($urandom_range(0, 11) == 0) begin
          if ($urandom_range(0, 1) == 1)
            send_request(REQ_NONE, IDX_W'($urandom_range(0, 7)),
                         IDX_W'($urandom_range(0, 7)), $urandom());
          else
            send_request($urandom_range(0, 1) ? REQ_WR_B : REQ_WR_A,
                         IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                         random_element());
        end
        have = is_b ? b_written[r * MAX_DIM + c] : a_written[r * MAX_DIM + c];
        if (!have || $urandom_range(0, 2) == 0)
          send_request(is_b ? REQ_WR_B : REQ_WR_A, IDX_W'(r), IDX_W'(c), random_element());
      end
    end
  endtask

  // One full product: configure m x k times k x n with random transposes,
  // load the stored regions and start. A mismatched run skips the loads.
  task automatic run_random_product(input int m, input int k, input int n,
                                    input bit mismatch, input bit hold_output);
    int kb, ar, ac, br, bc;
    bit ta, tb;
    gaps_on = ($urandom_range(0, 9) < 7);
    ta = $urandom_range(0, 1);
    tb = $urandom_range(0, 1);
    kb = mismatch ? (k % MAX_DIM) + 1 : k;
    ar = ta ? k : m;
    ac = ta ? m : k;
    br = tb ? n : kb;
    bc = tb ? kb : n;
    program_config(encode_dim(ar), encode_dim(ac), encode_dim(br), encode_dim(bc), ta, tb);
    if (!mismatch) begin
      load_region(1'b0, ar, ac);
      load_region(1'b1, br, bc);
    end
    if (hold_output) begin
      @(posedge clk);
      hold_off_left = HOLD_OFF_CYCLES;
    end
    send_start();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // 1x1 products through zero-valued size registers: positive and negative
  // saturation, the square of the most negative value, and -1 lsb rounding.
  task automatic test_fixed_point_extremes();
    program_config('0, '0, '0, '0, 1'b0, 1'b0);
    send_request(REQ_WR_A, '0, '0, SAT_MAX);
    send_request(REQ_WR_B, '0, '0, SAT_MAX);
    send_start();
    send_request(REQ_WR_A, '0, '0, SAT_MIN);
    send_start();
    send_request(REQ_WR_B, '0, '0, SAT_MIN);
    send_start();
    send_request(REQ_WR_A, '0, '0, 32'hFFFF_FFFF);
    send_request(REQ_WR_B, '0, '0, 32'h0000_0001);
    send_start();
  endtask

  // An unknown request must leave both stores alone; a write outside the
  // configured size but inside the store is kept and does not disturb C.
  task automatic test_ignored_request();
    send_request(REQ_NONE, '0, '0, 32'h1234_5678);
    send_request(REQ_WR_A, 3'd7, 3'd7, 32'hDEAD_BEEF);
    send_start();
  endtask

  // Inner dimensions that disagree, once through a clamped size register
  // and once through both transposes.
  task automatic test_dimension_mismatch();
    program_config(4'd1, 4'd15, 4'd7, 4'd1, 1'b0, 1'b0);
    send_start();
    program_config(4'd3, 4'd1, 4'd2, 4'd4, 1'b1, 1'b1);
    send_start();
  endtask

  // Stored A is 1x2 and B is 2x1; both transposed give a 2x2 outer product.
  task automatic test_transposed_operands();
    program_config(4'd1, 4'd2, 4'd2, 4'd1, 1'b1, 1'b1);
    send_request(REQ_WR_A, 3'd0, 3'd0, 32'h0002_0000);
    send_request(REQ_WR_A, 3'd0, 3'd1, 32'hFFFE_8000);
    send_request(REQ_WR_B, 3'd0, 3'd0, 32'h0000_C000);
    send_request(REQ_WR_B, 3'd1, 3'd0, 32'h0003_0000);
    send_start();
  endtask

  // Largest run: every entry of both stores, 64 results.
  task automatic test_full_size();
    run_random_product(MAX_DIM, MAX_DIM, MAX_DIM, 1'b0, 1'b0);
  endtask

  // Hold the output for a long stretch while the sender keeps offering
  // rewrites and a second start, so the block backs up into its input.
  task automatic test_backpressure();
    run_random_product(4, 4, 4, 1'b0, 1'b1);
    load_region(1'b0, 4, 4);
    load_region(1'b1, 4, 4);
    send_start();
  endtask

  // Mostly small random products, some up to full size, some mismatched.
  task automatic test_random_products();
    int m, k, n;
    while (items_sent - random_items_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        m = $urandom_range(1, MAX_DIM);
        k = $urandom_range(1, MAX_DIM);
        n = $urandom_range(1, MAX_DIM);
      end else begin
        m = $urandom_range(1, 3);
        k = $urandom_range(1, 3);
        n = $urandom_range(1, 3);
      end
      run_random_product(m, k, n, $urandom_range(0, 6) == 0, 1'b0);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_req_type      = REQ_WR_A;
    in_row_index     = '0;
    in_col_index     = '0;
    in_element_value = '0;
    cfg_wr_en        = 1'b0;
    cfg_index        = CFG_A_ROWS;
    cfg_data         = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fixed_point_extremes();
    test_ignored_request();
    test_dimension_mismatch();
    test_transposed_operands();

    random_items_start = items_sent;
    test_full_size();
    test_backpressure();
    test_random_products();

    settle_idle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- matrix_multiply_transpose.f -----
+incdir+sv
sv/mmt_pkg.sv
sv/mmt_store.sv
sv/mmt_mac.sv
sv/mmt_ctrl.sv
sv/matrix_multiply_transpose.sv
sv/mmt_checker.sv
tb/matrix_multiply_transpose_test.sv
